// ===== hdl/sitoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to ASCII conversion: shared definitions
// Constants, codes, status and state types and the digit character function.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int RADIX_W         = 6;
    localparam int BUFLEN_W        = 8;
    localparam int CHAR_W          = 8;
    localparam int STATUS_W        = 2;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 8;

    localparam logic [RADIX_W-1:0]  RADIX_RESET  = 6'd10;
    localparam logic [BUFLEN_W-1:0] BUFLEN_RESET = 8'd18;
    localparam logic [RADIX_W-1:0]  RADIX_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0]  RADIX_MAX    = 6'd36;
    localparam logic [BUFLEN_W-1:0] BUFLEN_MIN   = 8'd2;
    localparam logic [CHAR_W-1:0]   MINUS_CHAR   = 8'h2D;
    localparam logic [CHAR_W-1:0]   ZERO_CHAR    = 8'h30;
    localparam logic [CHAR_W-1:0]   ALPHA_CHAR   = 8'h61;
    localparam logic [CHAR_W-1:0]   ERROR_CHAR   = 8'h00;

    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX         = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_LENGTH = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_SHORT_BUF = 2'd1,
        ST_BAD_RADIX = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_CHECK,
        S_SIGN,
        S_DIGIT,
        S_ERROR
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10) begin
            c = ZERO_CHAR + {2'b00, d};
        end else if (d < RADIX_MAX) begin
            c = ALPHA_CHAR + {2'b00, d} - 8'd10;
        end else begin
            c = ZERO_CHAR;
        end
        return c;
    endfunction

endpackage

// ===== hdl/signed_int_to_ascii_radix_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to ASCII text in radix 2 to 36
// Bit-serial restoring division extracts the digits, which are then sent
// most significant first as one character per result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_signed_value
//  output    out        o_out_valid / i_out_stall  o_character, o_last, o_status
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  The digits come from the one-bit-per-cycle divider. A short buffer or a bad
//  radix is reported without any division, and text that is too long once the
//  digit limit or the buffer length is exceeded.
//  Reset loads radix 10 and buffer length 18 and clears all control state.
//  The input is stalled while an item is in work; a stalled output holds its
//  request, and the converter waits for the output register to free up.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_radix_core #(
    parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0]       i_signed_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sitoa_pkg::CHAR_W-1:0]        o_character,
    output logic                                o_last,
    output logic [sitoa_pkg::STATUS_W-1:0]      o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sitoa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sitoa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int MW = VALUE_WIDTH + 1;
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int IW = $clog2(VALUE_WIDTH);
    localparam int TW = sitoa_pkg::BUFLEN_W + 1;
    localparam int RW = sitoa_pkg::RADIX_W;

    sitoa_pkg::t_state r_state, n_state;

    logic [RW-1:0]                   r_radix;
    logic [sitoa_pkg::BUFLEN_W-1:0]  r_buffer_length;
    logic [MW-1:0]                   r_quot;
    logic [RW-1:0]                   r_rem;
    logic [CW-1:0]                   r_bit_cnt;
    logic [CW-1:0]                   r_count;
    logic                            r_neg;
    sitoa_pkg::t_status              r_err;
    logic [RW-1:0]                   r_digits [VALUE_WIDTH];

    logic                            r_out_valid;
    logic [sitoa_pkg::CHAR_W-1:0]    r_char;
    logic                            r_last;
    sitoa_pkg::t_status              r_status;

    logic                            in_accept;
    logic                            out_free;
    logic [RW:0]                     trial;
    logic                            trial_ge;
    logic [RW-1:0]                   step_rem;
    logic [MW-1:0]                   step_quot;
    logic                            bit_done;
    logic                            quot_zero;
    logic                            count_full;
    logic [TW-1:0]                   total_plus;
    logic                            fits;
    logic [CW-1:0]                   rd_ptr;
    logic [RW-1:0]                   rd_digit;
    logic                            short_buf;
    logic                            bad_radix;
    logic [MW-1:0]                   in_mag;

    logic                            out_load;
    logic [sitoa_pkg::CHAR_W-1:0]    out_char;
    logic                            out_last;
    sitoa_pkg::t_status              out_status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != sitoa_pkg::S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign short_buf = (r_buffer_length < sitoa_pkg::BUFLEN_MIN);
    assign bad_radix = (r_radix < sitoa_pkg::RADIX_MIN) || (r_radix > sitoa_pkg::RADIX_MAX);
    assign in_mag    = i_signed_value[VALUE_WIDTH-1]
                     ? -{i_signed_value[VALUE_WIDTH-1], i_signed_value}
                     : {1'b0, i_signed_value};

    assign trial      = {r_rem, r_quot[MW-1]};
    assign trial_ge   = (trial >= {1'b0, r_radix});
    assign step_rem   = trial_ge ? RW'(trial - {1'b0, r_radix}) : trial[RW-1:0];
    assign step_quot  = {r_quot[MW-2:0], trial_ge};
    assign bit_done   = (r_bit_cnt == CW'(VALUE_WIDTH));
    assign quot_zero  = (step_quot == '0);
    assign count_full = (r_count == CW'(VALUE_WIDTH - 1));

    assign total_plus = TW'(r_count) + TW'(r_neg) + TW'(1);
    assign fits       = (total_plus <= {1'b0, r_buffer_length});

    assign rd_ptr   = r_count - CW'(1);
    assign rd_digit = r_digits[rd_ptr[IW-1:0]];

    always_comb begin
        n_state = r_state;
        case (r_state)
            sitoa_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = (short_buf || bad_radix) ? sitoa_pkg::S_ERROR
                                                       : sitoa_pkg::S_DIVIDE;
                end
            end
            sitoa_pkg::S_DIVIDE: begin
                if (bit_done) begin
                    if (quot_zero) begin
                        n_state = sitoa_pkg::S_CHECK;
                    end else if (count_full) begin
                        n_state = sitoa_pkg::S_ERROR;
                    end
                end
            end
            sitoa_pkg::S_CHECK: begin
                if (!fits) begin
                    n_state = sitoa_pkg::S_ERROR;
                end else if (r_neg) begin
                    n_state = sitoa_pkg::S_SIGN;
                end else begin
                    n_state = sitoa_pkg::S_DIGIT;
                end
            end
            sitoa_pkg::S_SIGN: begin
                if (out_free) begin
                    n_state = sitoa_pkg::S_DIGIT;
                end
            end
            sitoa_pkg::S_DIGIT: begin
                if (out_free && (r_count == CW'(1))) begin
                    n_state = sitoa_pkg::S_IDLE;
                end
            end
            sitoa_pkg::S_ERROR: begin
                if (out_free) begin
                    n_state = sitoa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sitoa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_load   = 1'b0;
        out_char   = sitoa_pkg::ERROR_CHAR;
        out_last   = 1'b1;
        out_status = r_err;
        case (r_state)
            sitoa_pkg::S_SIGN: begin
                out_load   = out_free;
                out_char   = sitoa_pkg::MINUS_CHAR;
                out_last   = 1'b0;
                out_status = sitoa_pkg::ST_OK;
            end
            sitoa_pkg::S_DIGIT: begin
                out_load   = out_free;
                out_char   = sitoa_pkg::digit_char(rd_digit);
                out_last   = (r_count == CW'(1));
                out_status = sitoa_pkg::ST_OK;
            end
            sitoa_pkg::S_ERROR: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= sitoa_pkg::S_IDLE;
            r_radix         <= sitoa_pkg::RADIX_RESET;
            r_buffer_length <= sitoa_pkg::BUFLEN_RESET;
            r_out_valid     <= 1'b0;
            r_bit_cnt       <= '0;
            r_count         <= '0;
            r_neg           <= 1'b0;
            r_err           <= sitoa_pkg::ST_OK;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sitoa_pkg::CFG_RADIX: begin
                        r_radix <= i_cfg_data[RW-1:0];
                    end
                    sitoa_pkg::CFG_BUFFER_LENGTH: begin
                        r_buffer_length <= i_cfg_data;
                    end
                    default: begin
                        r_radix <= r_radix;
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                sitoa_pkg::S_IDLE: begin
                    r_bit_cnt <= '0;
                    r_count   <= '0;
                    r_neg     <= i_signed_value[VALUE_WIDTH-1];
                    r_err     <= short_buf ? sitoa_pkg::ST_SHORT_BUF
                                           : sitoa_pkg::ST_BAD_RADIX;
                end
                sitoa_pkg::S_DIVIDE: begin
                    if (bit_done) begin
                        r_bit_cnt <= '0;
                        r_count   <= r_count + CW'(1);
                        r_err     <= sitoa_pkg::ST_TOO_LONG;
                    end else begin
                        r_bit_cnt <= r_bit_cnt + CW'(1);
                    end
                end
                sitoa_pkg::S_CHECK: begin
                    r_err <= sitoa_pkg::ST_TOO_LONG;
                end
                sitoa_pkg::S_DIGIT: begin
                    if (out_free) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sitoa_pkg::S_IDLE) begin
            r_quot <= in_mag;
            r_rem  <= '0;
        end else if (r_state == sitoa_pkg::S_DIVIDE) begin
            r_quot <= step_quot;
            r_rem  <= bit_done ? '0 : step_rem;
            if (bit_done) begin
                r_digits[r_count[IW-1:0]] <= step_rem;
            end
        end
        if (out_load) begin
            r_char   <= out_char;
            r_last   <= out_last;
            r_status <= out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

// ===== bench/itoa_text_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix text checker
// Watches the value, text and register channels of the integer to text core.
// Each accepted value is converted here into the characters it should give
// under the current radix and buffer length. Each character coming out is
// compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
module itoa_text_checker #(
    parameter int VW = sitoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [VW-1:0]                i_signed_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [sitoa_pkg::CHAR_W-1:0]        i_character,
    input  logic                                i_last,
    input  logic [sitoa_pkg::STATUS_W-1:0]      i_status,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [sitoa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sitoa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_pending_chars,
    output int                                  o_values_converted,
    output int                                  o_chars_checked,
    output int                                  o_error_results
);

    typedef struct packed {
        logic [sitoa_pkg::CHAR_W-1:0] glyph;
        logic                         last;
        sitoa_pkg::t_status           status;
    } t_text_char;

    t_text_char                     expected_text [$];
    t_text_char                     want;
    logic [sitoa_pkg::RADIX_W-1:0]  radix_reg;
    logic [sitoa_pkg::BUFLEN_W-1:0] buflen_reg;
    int                 mismatch_count   = 0;
    int                 values_converted = 0;
    int                 chars_checked    = 0;
    int                 error_results    = 0;

    function automatic t_text_char make_char(input logic [sitoa_pkg::CHAR_W-1:0] glyph,
                                             input logic last,
                                             input sitoa_pkg::t_status status);
        t_text_char c;
        c.glyph  = glyph;
        c.last   = last;
        c.status = status;
        return c;
    endfunction

    function automatic void predict_text(input logic signed [VW-1:0] value);
        logic                          neg;
        logic [VW:0]                   magnitude;
        logic [VW:0]                   rest;
        logic [sitoa_pkg::RADIX_W-1:0] digits [VW];
        logic [sitoa_pkg::RADIX_W-1:0] d;
        logic [sitoa_pkg::CHAR_W-1:0]  glyph;
        int               n_digits;
        int               total;
        neg = value[VW-1];
        magnitude = {value[VW-1], value};
        if (neg) begin
            magnitude = ~magnitude + 1'b1;
        end
        if (buflen_reg < sitoa_pkg::BUFLEN_MIN) begin
            expected_text.push_back(make_char(sitoa_pkg::ERROR_CHAR, 1'b1,
                                              sitoa_pkg::ST_SHORT_BUF));
            error_results++;
            return;
        end
        if (radix_reg < sitoa_pkg::RADIX_MIN || radix_reg > sitoa_pkg::RADIX_MAX) begin
            expected_text.push_back(make_char(sitoa_pkg::ERROR_CHAR, 1'b1,
                                              sitoa_pkg::ST_BAD_RADIX));
            error_results++;
            return;
        end
        n_digits = 0;
        rest = magnitude;
        do begin
            if (n_digits < VW) begin
                digits[n_digits] = sitoa_pkg::RADIX_W'(rest % radix_reg);
            end
            rest = rest / radix_reg;
            n_digits++;
        end while (rest != 0);
        total = n_digits + (neg ? 1 : 0);
        if (total + 1 > int'(buflen_reg) || n_digits > VW) begin
            expected_text.push_back(make_char(sitoa_pkg::ERROR_CHAR, 1'b1,
                                              sitoa_pkg::ST_TOO_LONG));
            error_results++;
            return;
        end
        if (neg) begin
            expected_text.push_back(make_char(sitoa_pkg::MINUS_CHAR, 1'b0,
                                              sitoa_pkg::ST_OK));
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            d = digits[i];
            if (d < 10) begin
                glyph = sitoa_pkg::ZERO_CHAR + sitoa_pkg::CHAR_W'(d);
            end else begin
                glyph = sitoa_pkg::ALPHA_CHAR + sitoa_pkg::CHAR_W'(d)
                      - sitoa_pkg::CHAR_W'(10);
            end
            expected_text.push_back(make_char(glyph, i == 0, sitoa_pkg::ST_OK));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_text.delete();
            radix_reg  = sitoa_pkg::RADIX_RESET;
            buflen_reg = sitoa_pkg::BUFLEN_RESET;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                chars_checked++;
                if (expected_text.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected character %h last %b status %0d, none expected",
                             $time, i_character, i_last, i_status);
                end else begin
                    want = expected_text.pop_front();
                    if (want.glyph !== i_character || want.last !== i_last ||
                        want.status !== i_status) begin
                        mismatch_count++;
                        $display("%0t: expected char %h last %b status %0d, got char %h last %b status %0d",
                                 $time, want.glyph, want.last, want.status,
                                 i_character, i_last, i_status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_text(i_signed_value);
                values_converted++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sitoa_pkg::CFG_RADIX: begin
                        radix_reg = i_cfg_data[sitoa_pkg::RADIX_W-1:0];
                    end
                    sitoa_pkg::CFG_BUFFER_LENGTH: begin
                        buflen_reg = i_cfg_data[sitoa_pkg::BUFLEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_mismatches       <= mismatch_count;
        o_pending_chars    <= expected_text.size();
        o_values_converted <= values_converted;
        o_chars_checked    <= chars_checked;
        o_error_results    <= error_results;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to radix text core testbench
// Drives values and register writes into the core, with random gaps on the
// sender side and random stalls on the receiver side, and lets the checker
// judge every character that comes out.
// ----------------------------------------------------------------------------
module tb;

    localparam int VW          = sitoa_pkg::VALUE_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_TAIL  = 40;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic                                in_stall;
    logic signed [VW-1:0]                signed_value = '0;
    logic                                out_valid;
    logic                                out_stall    = 1'b0;
    logic [sitoa_pkg::CHAR_W-1:0]        character;
    logic                                last;
    logic [sitoa_pkg::STATUS_W-1:0]      status;
    logic                                cfg_valid    = 1'b0;
    logic                                cfg_ready;
    logic [sitoa_pkg::CFG_INDEX_W-1:0]   cfg_index    = sitoa_pkg::CFG_RADIX;
    logic [sitoa_pkg::CFG_DATA_W-1:0]    cfg_data     = '0;

    int mismatches;
    int pending_chars;
    int values_converted;
    int chars_checked;
    int error_results;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    bit hold_request   = 1'b0;
    int send_idle_mix [4] = '{0, 48, 0, 20};
    int stall_mix     [4] = '{0, 0, 48, 20};

    signed_int_to_ascii_radix_core #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_signed_value (signed_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_character    (character),
        .o_last         (last),
        .o_status       (status),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    itoa_text_checker #(
        .VW(VW)
    ) checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_signed_value     (signed_value),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_character        (character),
        .i_last             (last),
        .i_status           (status),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_mismatches       (mismatches),
        .o_pending_chars    (pending_chars),
        .o_values_converted (values_converted),
        .o_chars_checked    (chars_checked),
        .o_error_results    (error_results)
    );

    initial begin
        forever begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing.", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    // The receiver stalls at random, and once holds off long enough for the
    // core to fill up and stall its own input.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_value(input logic signed [VW-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        signed_value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle_config(input logic [sitoa_pkg::CFG_DATA_W-1:0] radix_data,
                                 input logic [sitoa_pkg::CFG_DATA_W-1:0] buflen_data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sitoa_pkg::CFG_RADIX;
        cfg_data  <= radix_data;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= sitoa_pkg::CFG_BUFFER_LENGTH;
        cfg_data  <= buflen_data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [sitoa_pkg::CFG_DATA_W-1:0] radix_data;
        logic [sitoa_pkg::CFG_DATA_W-1:0] buflen_data;
        logic [VW-1:0]                    draw;
        int                               pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(16'sh0000);
        send_value(16'sh7FFF);
        send_value(16'sh8000);
        send_value(16'shFFFF);
        settle_config(8'hE4, 8'hFF);
        send_value(16'sd35);
        send_value(16'sh8000);
        send_value(16'sd12345);
        settle_config(8'h02, 8'd18);
        send_value(16'sh8000);
        send_value(16'sh8001);
        send_value(16'sh7FFF);
        settle_config(8'h02, 8'd17);
        send_value(16'sh8001);
        settle_config(8'h0A, 8'd2);
        send_value(16'sd7);
        send_value(16'sd10);
        send_value(-16'sd7);
        settle_config(8'h0A, 8'd1);
        send_value(16'sd5);
        settle_config(8'h0A, 8'd0);
        send_value(-16'sd5);
        settle_config(8'h01, 8'd18);
        send_value(16'sd5);
        settle_config(8'hC0, 8'd18);
        send_value(16'sd5);
        settle_config(8'h25, 8'd18);
        send_value(16'sd5);
        settle_config(8'h3F, 8'd18);
        send_value(16'sd5);
        settle_config(8'hC0, 8'd0);
        send_value(16'sd5);
        settle_config(8'h10, 8'hC8);
        send_value(16'sh7ABC);
        send_value(16'shABCD);

        for (int mix = 0; mix < 4; mix++) begin
            send_idle_pct = send_idle_mix[mix];
            stall_pct     = stall_mix[mix];
            for (int seg = 0; seg < 3; seg++) begin
                case (seg)
                    0: begin
                        settle_config({2'($urandom), 6'd2}, 8'd18);
                    end
                    1: begin
                        settle_config({2'($urandom), 6'd36}, 8'd255);
                    end
                    default: begin
                        if ($urandom_range(99) < 85) begin
                            radix_data = {2'($urandom), 6'($urandom_range(36, 2))};
                        end else begin
                            radix_data = 8'($urandom);
                        end
                        pick = $urandom_range(9);
                        if (pick < 7) begin
                            buflen_data = 8'($urandom_range(255, 8));
                        end else if (pick < 9) begin
                            buflen_data = 8'($urandom_range(7, 2));
                        end else begin
                            buflen_data = 8'($urandom_range(1, 0));
                        end
                        settle_config(radix_data, buflen_data);
                    end
                endcase
                if (mix == 0 && seg == 1) begin
                    hold_request = 1'b1;
                end
                repeat (30) begin
                    case ($urandom_range(9))
                        0: begin
                            case ($urandom_range(4))
                                0: draw = 16'h8000;
                                1: draw = 16'h7FFF;
                                2: draw = 16'h0000;
                                3: draw = 16'hFFFF;
                                default: draw = 16'h0001;
                            endcase
                        end
                        1, 2: begin
                            draw = 16'($urandom_range(40));
                            if ($urandom_range(1) == 1) begin
                                draw = -draw;
                            end
                        end
                        default: begin
                            draw = 16'($urandom);
                        end
                    endcase
                    send_value(draw);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Converted %0d values: %0d characters checked, %0d of them error results.",
                 values_converted, chars_checked, error_results);
        $display("Radices 2 to 36 and invalid ones, buffers 0 to 255, four gap mixes, one long hold.");
        if (mismatches == 0 && pending_chars == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sitoa_pkg.sv
hdl/signed_int_to_ascii_radix_core.sv
bench/itoa_text_checker.sv
bench/tb.sv
